### sv/led_frame_store_spi_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - assertion macros
// Shorthand for the clocked, reset-qualified checks of the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_FRAME_STORE_SPI_ENCODER_CORE_DEFINES_SVH
`define LED_FRAME_STORE_SPI_ENCODER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LFSE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfse checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define LFSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfse checker: next-cycle property failed");

`endif

### sv/lfse_pkg.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - package
// Shared widths, codes, types and the SPI bit pattern encoder.
// ----------------------------------------------------------------------------
package lfse_pkg;

   // default geometry
   localparam int PIXEL_COUNT_DEF    = 256;
   localparam int ROW_LENGTH_DEF     = 16;
   localparam int PREAMBLE_WORDS_DEF = 15;

   // field widths
   localparam int CHAN_W     = 8;
   localparam int BRIGHT_W   = 7;
   localparam int COORD_W    = 4;
   localparam int COORD_MAX  = (1 << COORD_W) - 1;
   localparam int WORD_W     = 64;
   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 4;

   // scaling: floor(p / 100) as (p * 5243) >> 19, exact for p below 2^15
   localparam int               PROD_W      = CHAN_W + BRIGHT_W;
   localparam int               RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int               RECIP_SHIFT = 19;
   localparam int               QUOT_W      = CHAN_W + 1;

   // one word per color channel
   localparam int CHANNELS   = 3;
   localparam int EMIT_WORDS = CHANNELS;

   // register indexes
   localparam logic [1:0] REG_BRIGHTNESS   = 2'd0;
   localparam logic [1:0] REG_ZERO_PATTERN = 2'd1;
   localparam logic [1:0] REG_ONE_PATTERN  = 2'd2;

   // register reset values
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST   = 7'd100;
   localparam logic [CHAN_W-1:0]   ZERO_PATTERN_RST = 8'd192;
   localparam logic [CHAN_W-1:0]   ONE_PATTERN_RST  = 8'd248;

   typedef enum logic [1:0] {
      REQ_SET_PIXEL     = 2'd0,
      REQ_FILL_ALL      = 2'd1,
      REQ_EMIT_PIXEL    = 2'd2,
      REQ_EMIT_PREAMBLE = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_FILL,
      ST_READ,
      ST_EMIT,
      ST_PREAMBLE
   } ctrl_state_type;

   typedef struct packed {
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] brightness;
      logic [CHAN_W-1:0]   zero_pattern;
      logic [CHAN_W-1:0]   one_pattern;
   } csr_regs_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // map each color bit to one pattern byte, bit 7 into the top byte
   function automatic logic [WORD_W-1:0] encode_channel(
      input logic [CHAN_W-1:0] chan,
      input logic [CHAN_W-1:0] zero_pat,
      input logic [CHAN_W-1:0] one_pat
   );
      logic [WORD_W-1:0] word;
      word = '0;
      for (int k = 0; k < CHAN_W; k++) begin
         word[k*CHAN_W +: CHAN_W] = chan[k] ? one_pat : zero_pat;
      end
      return word;
   endfunction

endpackage

### sv/lfse_csr.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - register file
// APB-style access to brightness and the two SPI bit patterns.
// ----------------------------------------------------------------------------
module lfse_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lfse_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lfse_pkg::DATA_W-1:0]      pwdata,
   output logic [lfse_pkg::DATA_W-1:0]      prdata,
   output logic                             pready,
   output lfse_pkg::csr_regs_type           regs
);
   import lfse_pkg::*;

   csr_regs_type     regs_ff;
   csr_regs_type     regs_in;
   logic [1:0]       reg_index;
   logic             wr_strobe;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign regs      = regs_ff;

   // decode a completed write
   always_comb begin
      regs_in = regs_ff;
      if (wr_strobe) begin
         case (reg_index)
            REG_BRIGHTNESS:   regs_in.brightness   = pwdata[BRIGHT_W-1:0];
            REG_ZERO_PATTERN: regs_in.zero_pattern = pwdata[CHAN_W-1:0];
            REG_ONE_PATTERN:  regs_in.one_pattern  = pwdata[CHAN_W-1:0];
            default:          regs_in = regs_ff;
         endcase
      end
   end

   // return the addressed register
   always_comb begin
      case (reg_index)
         REG_BRIGHTNESS:   prdata = DATA_W'(regs_ff.brightness);
         REG_ZERO_PATTERN: prdata = DATA_W'(regs_ff.zero_pattern);
         REG_ONE_PATTERN:  prdata = DATA_W'(regs_ff.one_pattern);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.brightness   <= BRIGHTNESS_RST;
         regs_ff.zero_pattern <= ZERO_PATTERN_RST;
         regs_ff.one_pattern  <= ONE_PATTERN_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

### sv/lfse_scale.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - brightness scaler
// Two-stage pipe: channel times brightness, then divide by 100 and saturate.
// ----------------------------------------------------------------------------
module lfse_scale (
   input  logic                           clock,
   input  lfse_pkg::pixel_type            color,
   input  logic [lfse_pkg::BRIGHT_W-1:0]  brightness,
   output lfse_pkg::pixel_type            scaled
);
   import lfse_pkg::*;

   logic [CHAN_W-1:0]          chan       [CHANNELS];
   logic [PROD_W-1:0]          prod_in    [CHANNELS];
   logic [PROD_W-1:0]          prod_ff    [CHANNELS];
   logic [PROD_W+RECIP_W-1:0]  recip_prod [CHANNELS];
   logic [QUOT_W-1:0]          quot       [CHANNELS];
   logic [CHAN_W-1:0]          sat_in     [CHANNELS];
   logic [CHAN_W-1:0]          sat_ff     [CHANNELS];

   // stage one: scale by percent; stage two: reciprocal divide and clamp
   always_comb begin
      chan[0] = color.green;
      chan[1] = color.red;
      chan[2] = color.blue;
      for (int i = 0; i < CHANNELS; i++) begin
         prod_in[i]    = PROD_W'(chan[i]) * PROD_W'(brightness);
         recip_prod[i] = (PROD_W+RECIP_W)'(prod_ff[i]) * (PROD_W+RECIP_W)'(RECIP_100);
         quot[i]       = recip_prod[i][RECIP_SHIFT +: QUOT_W];
         sat_in[i]     = quot[i][CHAN_W] ? {CHAN_W{1'b1}} : quot[i][CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sat_ff  <= sat_in;
   end

   assign scaled.green = sat_ff[0];
   assign scaled.red   = sat_ff[1];
   assign scaled.blue  = sat_ff[2];

endmodule

### sv/lfse_store.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - frame store
// Single-port pixel memory with registered read data.
// ----------------------------------------------------------------------------
module lfse_store #(
   parameter int PIXEL_COUNT = lfse_pkg::PIXEL_COUNT_DEF
) (
   input  logic                                        clock,
   input  lfse_pkg::mem_ctl_type                       ctl,
   input  logic [((PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1)-1:0] addr,
   input  lfse_pkg::pixel_type                         wr_data,
   output lfse_pkg::pixel_type                         rd_data
);
   import lfse_pkg::*;

   pixel_type mem [PIXEL_COUNT];
   pixel_type rd_data_ff;

   // write or read one entry; read data is registered and holds
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lfse_ctrl.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - sequencer
// Takes requests, drives the store sweep, reads pixels and emits SPI words.
// ----------------------------------------------------------------------------
module lfse_ctrl #(
   parameter int PIXEL_COUNT    = lfse_pkg::PIXEL_COUNT_DEF,
   parameter int ROW_LENGTH     = lfse_pkg::ROW_LENGTH_DEF,
   parameter int PREAMBLE_WORDS = lfse_pkg::PREAMBLE_WORDS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic [1:0]                                  req_type,
   input  logic [lfse_pkg::COORD_W-1:0]                req_x,
   input  logic [lfse_pkg::COORD_W-1:0]                req_y,
   input  logic [lfse_pkg::CHAN_W-1:0]                 req_red,
   input  logic [lfse_pkg::CHAN_W-1:0]                 req_green,
   input  logic [lfse_pkg::CHAN_W-1:0]                 req_blue,
   input  lfse_pkg::csr_regs_type                      regs,
   output lfse_pkg::pixel_type                         color,
   input  lfse_pkg::pixel_type                         scaled,
   output lfse_pkg::mem_ctl_type                       mem_ctl,
   output logic [((PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1)-1:0] mem_addr,
   output lfse_pkg::pixel_type                         mem_wr_data,
   input  lfse_pkg::pixel_type                         mem_rd_data,
   output logic                                        rsp_valid,
   output logic [lfse_pkg::WORD_W-1:0]                 rsp_spi_word,
   output logic                                        rsp_word_last
);
   import lfse_pkg::*;

   localparam int ADDR_W   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int IDX_W    = $clog2(COORD_MAX + COORD_MAX * ROW_LENGTH + 1);
   localparam int CMP_W    = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 2;
   localparam int CNT_SPAN = (PREAMBLE_WORDS > EMIT_WORDS) ? PREAMBLE_WORDS : EMIT_WORDS;
   localparam int CNT_W    = $clog2(CNT_SPAN);

   ctrl_state_type        state_ff, state_in;
   req_code_type          code_ff, code_in;
   req_code_type          req_code;
   pixel_type             color_ff, color_in;
   logic [IDX_W-1:0]      req_idx;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  in_range_ff, in_range_in;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  sweep_last;
   logic                  emit_last;
   logic                  pre_last;
   pixel_type             emit_pixel;
   logic [CHAN_W-1:0]     emit_chan;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic                  rsp_last_ff, rsp_last_in;

   assign req_code   = req_code_type'(req_type);
   assign req_idx    = IDX_W'(req_x) + IDX_W'(req_y) * IDX_W'(ROW_LENGTH);
   assign sweep_last = (sweep_ff == ADDR_W'(PIXEL_COUNT - 1));
   assign emit_last  = (cnt_ff == CNT_W'(EMIT_WORDS - 1));
   assign pre_last   = (cnt_ff == CNT_W'(PREAMBLE_WORDS - 1));
   assign busy       = (state_ff != ST_IDLE);
   assign color      = color_ff;

   // an out-of-range emit sends an all-zero pixel
   assign emit_pixel = in_range_ff ? mem_rd_data : '0;

   // green, red, blue in word order
   always_comb begin
      if (cnt_ff == CNT_W'(0)) begin
         emit_chan = emit_pixel.green;
      end else if (cnt_ff == CNT_W'(1)) begin
         emit_chan = emit_pixel.red;
      end else begin
         emit_chan = emit_pixel.blue;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (req_code)
                  REQ_SET_PIXEL, REQ_FILL_ALL: state_in = ST_MUL;
                  REQ_EMIT_PIXEL:              state_in = ST_READ;
                  REQ_EMIT_PREAMBLE:           state_in = ST_PREAMBLE;
                  default:                     state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   state_in = (code_ff == REQ_FILL_ALL) ? ST_FILL : ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         ST_FILL: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_READ:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_last) state_in = ST_IDLE;
         end
         ST_PREAMBLE: begin
            if (pre_last) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath, store access and result words
   always_comb begin
      code_in       = code_ff;
      color_in      = color_ff;
      addr_in       = addr_ff;
      in_range_in   = in_range_ff;
      sweep_in      = sweep_ff;
      cnt_in        = cnt_ff;
      mem_ctl       = '0;
      mem_addr      = addr_ff;
      mem_wr_data   = scaled;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = '0;
      rsp_last_in   = 1'b0;
      case (state_ff)
         ST_CLEAR, ST_FILL: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = sweep_ff;
            mem_wr_data   = (state_ff == ST_CLEAR) ? '0 : scaled;
            sweep_in      = sweep_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (start) begin
               code_in        = req_code;
               color_in.green = req_green;
               color_in.red   = req_red;
               color_in.blue  = req_blue;
               addr_in        = ADDR_W'(req_idx);
               in_range_in    = (CMP_W'(req_idx) < CMP_W'(PIXEL_COUNT));
               cnt_in         = '0;
               sweep_in       = '0;
            end
         end
         ST_WRITE: begin
            mem_ctl.wr_en = in_range_ff;
         end
         ST_READ: begin
            mem_ctl.rd_en = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = encode_channel(emit_chan, regs.zero_pattern, regs.one_pattern);
            rsp_last_in  = emit_last;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
         ST_PREAMBLE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = pre_last;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      color_ff    <= color_in;
      addr_ff     <= addr_in;
      in_range_ff <= in_range_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_spi_word  = rsp_word_ff;
   assign rsp_word_last = rsp_last_ff;

endmodule

### sv/led_frame_store_spi_encoder_core.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder core
// Pixel frame store with brightness scaling and GRB SPI bit pattern output.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                  Handshake
// --------  -------------------------------------  ------------------------------
// request   req_type, req_x, req_y, req_red/green  taken when start & !busy
//           /blue
// result    rsp_spi_word, rsp_word_last            rsp_valid qualifies each word
// config    csr_psel/penable/pwrite/paddr/pwdata   written on psel&penable&pwrite
//           csr_prdata, csr_pready                 pready tied high
//
// Set pixel: accept, two scaler stages, then one store write.
// Fill all: as set pixel, but the single store write port sweeps every entry.
// Emit pixel: one store read, then three words back to back; the first word
//   is registered out of the EMIT state, after the READ state. Preamble:
//   PREAMBLE_WORDS words, registered out of the PREAMBLE state.
// After reset the store is cleared one entry a cycle, every entry in turn,
//   with busy high; register writes are taken throughout.
// Results cannot be stalled; busy falls as the last word shows on rsp_valid.
// ----------------------------------------------------------------------------
module led_frame_store_spi_encoder_core #(
   parameter int PIXEL_COUNT    = lfse_pkg::PIXEL_COUNT_DEF,
   parameter int ROW_LENGTH     = lfse_pkg::ROW_LENGTH_DEF,
   parameter int PREAMBLE_WORDS = lfse_pkg::PREAMBLE_WORDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic [lfse_pkg::COORD_W-1:0]     req_x,
   input  logic [lfse_pkg::COORD_W-1:0]     req_y,
   input  logic [lfse_pkg::CHAN_W-1:0]      req_red,
   input  logic [lfse_pkg::CHAN_W-1:0]      req_green,
   input  logic [lfse_pkg::CHAN_W-1:0]      req_blue,
   output logic                             rsp_valid,
   output logic [lfse_pkg::WORD_W-1:0]      rsp_spi_word,
   output logic                             rsp_word_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lfse_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lfse_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [lfse_pkg::DATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import lfse_pkg::*;

   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   csr_regs_type       regs;
   pixel_type          color;
   pixel_type          scaled;
   mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]  mem_addr;
   pixel_type          mem_wr_data;
   pixel_type          mem_rd_data;

   // configuration registers
   lfse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .regs    (regs)
   );

   // brightness scaling pipe
   lfse_scale u_scale (
      .clock      (clock),
      .color      (color),
      .brightness (regs.brightness),
      .scaled     (scaled)
   );

   // pixel memory
   lfse_store #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // request sequencer and word output
   lfse_ctrl #(
      .PIXEL_COUNT    (PIXEL_COUNT),
      .ROW_LENGTH     (ROW_LENGTH),
      .PREAMBLE_WORDS (PREAMBLE_WORDS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .regs          (regs),
      .color         (color),
      .scaled        (scaled),
      .mem_ctl       (mem_ctl),
      .mem_addr      (mem_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_data   (mem_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_spi_word  (rsp_spi_word),
      .rsp_word_last (rsp_word_last)
   );

endmodule

### sv/lfse_checker.sv
// ----------------------------------------------------------------------------
// LED frame store SPI encoder - port checker
// Checks word runs, accept spacing and the post-reset clear on the ports.
// ----------------------------------------------------------------------------
`include "led_frame_store_spi_encoder_core_defines.svh"

module lfse_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_word_last
);

   // the store clear holds requests off right after reset
   `LFSE_ASSERT_NOW(a_clear_after_reset, $fell(reset), busy)

   // a freshly accepted item shows no word in the following cycle
   `LFSE_ASSERT_NEXT(a_gap_after_accept, start && !busy, !rsp_valid)

   // words of one run come back to back
   `LFSE_ASSERT_NEXT(a_run_contiguous, rsp_valid && !rsp_word_last, rsp_valid)

   // a run ends cleanly after its last word
   `LFSE_ASSERT_NEXT(a_run_ends, rsp_valid && rsp_word_last, !rsp_valid)

endmodule

bind led_frame_store_spi_encoder_core lfse_checker u_lfse_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_word_last (rsp_word_last)
);

### verif/tb_led_frame_store_spi_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame store SPI encoder core - testbench
// Drives pixel set, fill, emit and preamble requests through the command
// port, reprograms brightness and SPI patterns over the register port
// between phases, and checks every SPI word against a local frame store
// predictor. A directed table comes first, then random phases.
// ----------------------------------------------------------------------------
module tb_led_frame_store_spi_encoder_core;
   import lfse_pkg::*;

   localparam int PIXELS        = PIXEL_COUNT_DEF;
   localparam int ROW_LEN       = ROW_LENGTH_DEF;
   localparam int PREAMBLE_LEN  = PREAMBLE_WORDS_DEF;
   localparam int SETTLE_CYCLES = PIXEL_COUNT_DEF + 16;
   localparam int DIR_ROWS      = 22;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 15;
   localparam int QUIET_PHASE   = 3;
   localparam int SHOW_LIMIT    = 10;

   typedef struct packed {
      req_code_type      kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } led_req_type;

   // directed row: typed expectation used for every word when has_word is set
   typedef struct packed {
      led_req_type       req;
      logic              has_word;
      logic [WORD_W-1:0] word;
   } dir_row_type;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              last;
   } spi_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic [COORD_W-1:0]    req_x;
   logic [COORD_W-1:0]    req_y;
   logic [CHAN_W-1:0]     req_red;
   logic [CHAN_W-1:0]     req_green;
   logic [CHAN_W-1:0]     req_blue;
   logic                  rsp_valid;
   logic [WORD_W-1:0]     rsp_spi_word;
   logic                  rsp_word_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   // predictor state
   pixel_type           frame_model [PIXELS];
   logic [BRIGHT_W-1:0] bright_model;
   logic [CHAN_W-1:0]   zero_model;
   logic [CHAN_W-1:0]   one_model;

   spi_result_type      pending_words [$];
   logic [7:0]          recent_pixels [$];
   int unsigned         err_count;
   bit                  steady;

   dir_row_type         dir_rows [DIR_ROWS];
   csr_regs_type        phase_cfg [PHASES];

   led_frame_store_spi_encoder_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_spi_word  (rsp_spi_word),
      .rsp_word_last (rsp_word_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #6 clock = ~clock;

   // scale one channel by the brightness percent, saturating at full scale
   function automatic logic [CHAN_W-1:0] scale_level(input logic [CHAN_W-1:0] c);
      int unsigned v;
      v = int'(c) * int'(bright_model) / 100;
      return (v > 255) ? 8'hFF : 8'(v);
   endfunction

   // one pattern byte per color bit, bit 7 in the top byte
   function automatic logic [WORD_W-1:0] spi_bytes(input logic [CHAN_W-1:0] c);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int k = CHAN_W - 1; k >= 0; k--) begin
         w = {w[WORD_W-CHAN_W-1:0], (c[k] ? one_model : zero_model)};
      end
      return w;
   endfunction

   // favor the extremes of a color level
   function automatic logic [CHAN_W-1:0] pick_level();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // update the frame store copy and queue the SPI words the request causes
   task automatic model_led_request(input led_req_type r, input logic has_word,
                                    input logic [WORD_W-1:0] typed_word);
      pixel_type      px;
      int unsigned    idx;
      spi_result_type res;
      idx = int'(r.x) + int'(r.y) * ROW_LEN;
      px.green = scale_level(r.green);
      px.red   = scale_level(r.red);
      px.blue  = scale_level(r.blue);
      case (r.kind)
         REQ_SET_PIXEL: begin
            // drop writes beyond the store
            if (idx < PIXELS) frame_model[idx] = px;
         end
         REQ_FILL_ALL: begin
            foreach (frame_model[i]) frame_model[i] = px;
         end
         REQ_EMIT_PIXEL: begin
            // a pixel beyond the store reads as all off
            px = (idx < PIXELS) ? frame_model[idx] : '0;
            for (int c = 0; c < EMIT_WORDS; c++) begin
               res.word = has_word ? typed_word :
                          spi_bytes(c == 0 ? px.green : (c == 1 ? px.red : px.blue));
               res.last = (c == EMIT_WORDS - 1);
               pending_words.push_back(res);
            end
         end
         default: begin
            for (int i = 0; i < PREAMBLE_LEN; i++) begin
               res.word = has_word ? typed_word : '0;
               res.last = (i == PREAMBLE_LEN - 1);
               pending_words.push_back(res);
            end
         end
      endcase
   endtask

   // present one item and hold it until accepted; start is left high
   task automatic send_request(input led_req_type r, input logic has_word,
                               input logic [WORD_W-1:0] typed_word);
      if (!steady && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= r.kind;
      req_x     <= r.x;
      req_y     <= r.y;
      req_red   <= r.red;
      req_green <= r.green;
      req_blue  <= r.blue;
      do @(posedge clock); while (busy);
      model_led_request(r, has_word, typed_word);
   endtask

   // lower start and wait until every word is out and the block has settled
   task automatic drain_words();
      start <= 1'b0;
      while (pending_words.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BRIGHTNESS:   bright_model = val[BRIGHT_W-1:0];
         REG_ZERO_PATTERN: zero_model   = val[CHAN_W-1:0];
         REG_ONE_PATTERN:  one_model    = val[CHAN_W-1:0];
         default: ;
      endcase
   endtask

   // random item, mostly sets followed by emits of recently set pixels
   task automatic pick_request(output led_req_type r);
      int unsigned roll;
      roll    = $urandom_range(99);
      r.x     = COORD_W'($urandom_range(COORD_MAX));
      r.y     = COORD_W'($urandom_range(COORD_MAX));
      r.red   = pick_level();
      r.green = pick_level();
      r.blue  = pick_level();
      if (roll < 40) begin
         r.kind = REQ_SET_PIXEL;
         recent_pixels.push_back({r.y, r.x});
         if (recent_pixels.size() > 8) void'(recent_pixels.pop_front());
      end else if (roll < 78) begin
         r.kind = REQ_EMIT_PIXEL;
         if (recent_pixels.size() != 0 && $urandom_range(99) < 70) begin
            {r.y, r.x} = recent_pixels[$urandom_range(recent_pixels.size() - 1)];
         end
      end else if (roll < 81) begin
         r.kind = REQ_FILL_ALL;
      end else begin
         r.kind = REQ_EMIT_PREAMBLE;
      end
   endtask

   // compare each word with the oldest expectation
   always @(posedge clock) begin : word_check
      spi_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            err_count++;
            if (err_count <= SHOW_LIMIT)
               $display("unexpected word %h last %b", rsp_spi_word, rsp_word_last);
         end else begin
            want = pending_words.pop_front();
            if (rsp_spi_word !== want.word || rsp_word_last !== want.last) begin
               err_count++;
               if (err_count <= SHOW_LIMIT)
                  $display("word mismatch: expected %h last %b, got %h last %b",
                           want.word, want.last, rsp_spi_word, rsp_word_last);
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("led_frame_store_spi_encoder_core test failed");
      $finish;
   end

   initial begin : stimulus
      led_req_type r;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_type    = REQ_SET_PIXEL;
      req_x       = '0;
      req_y       = '0;
      req_red     = '0;
      req_green   = '0;
      req_blue    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      err_count   = 0;
      steady      = 1'b0;

      foreach (frame_model[i]) frame_model[i] = '0;
      bright_model = BRIGHTNESS_RST;
      zero_model   = ZERO_PATTERN_RST;
      one_model    = ONE_PATTERN_RST;

      // reset patterns: zero bit C0, one bit F8; full brightness keeps 255 exact
      dir_rows = '{
         '{'{REQ_EMIT_PIXEL,    4'd0,  4'd0,  8'h00, 8'h00, 8'h00}, 1'b1, 64'hC0C0_C0C0_C0C0_C0C0},
         '{'{REQ_EMIT_PREAMBLE, 4'd0,  4'd0,  8'h00, 8'h00, 8'h00}, 1'b1, 64'h0},
         '{'{REQ_SET_PIXEL,     4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd15, 4'd15, 8'h00, 8'h00, 8'h00}, 1'b1, 64'hF8F8_F8F8_F8F8_F8F8},
         '{'{REQ_SET_PIXEL,     4'd0,  4'd15, 8'h80, 8'h01, 8'h55}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd0,  4'd15, 8'h00, 8'h00, 8'h00}, 1'b0, 64'h0},
         '{'{REQ_SET_PIXEL,     4'd15, 4'd0,  8'hAA, 8'h0F, 8'hF0}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd15, 4'd0,  8'h00, 8'h00, 8'h00}, 1'b0, 64'h0},
         '{'{REQ_SET_PIXEL,     4'd7,  4'd8,  8'h01, 8'h02, 8'h03}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd7,  4'd8,  8'hFF, 8'hFF, 8'hFF}, 1'b0, 64'h0},
         '{'{REQ_FILL_ALL,      4'd0,  4'd0,  8'hFF, 8'hFF, 8'hFF}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd3,  4'd9,  8'h00, 8'h00, 8'h00}, 1'b1, 64'hF8F8_F8F8_F8F8_F8F8},
         '{'{REQ_SET_PIXEL,     4'd4,  4'd4,  8'd200, 8'd100, 8'd50}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd4,  4'd4,  8'h00, 8'h00, 8'h00}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd5,  4'd4,  8'h00, 8'h00, 8'h00}, 1'b1, 64'hF8F8_F8F8_F8F8_F8F8},
         '{'{REQ_FILL_ALL,      4'd9,  4'd2,  8'h00, 8'h00, 8'h00}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd15, 4'd15, 8'h00, 8'h00, 8'h00}, 1'b1, 64'hC0C0_C0C0_C0C0_C0C0},
         '{'{REQ_EMIT_PIXEL,    4'd4,  4'd4,  8'h00, 8'h00, 8'h00}, 1'b1, 64'hC0C0_C0C0_C0C0_C0C0},
         '{'{REQ_EMIT_PREAMBLE, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 64'h0},
         '{'{REQ_SET_PIXEL,     4'd15, 4'd15, 8'h7F, 8'hFE, 8'h81}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd15, 4'd15, 8'h00, 8'h00, 8'h00}, 1'b0, 64'h0},
         '{'{REQ_EMIT_PIXEL,    4'd0,  4'd0,  8'h00, 8'h00, 8'h00}, 1'b1, 64'hC0C0_C0C0_C0C0_C0C0}
      };

      // saturating, dark, just above full, near zero; the last two are random
      phase_cfg = '{
         '{7'd127, 8'h00, 8'hFF},
         '{7'd0,   8'hFF, 8'h00},
         '{7'd101, 8'hC0, 8'hF8},
         '{7'd1,   8'h55, 8'hAA},
         '{7'd0,   8'h00, 8'h00},
         '{7'd0,   8'h00, 8'h00}
      };
      for (int p = PHASES - 2; p < PHASES; p++) begin
         phase_cfg[p].brightness   = BRIGHT_W'($urandom_range(127));
         phase_cfg[p].zero_pattern = CHAN_W'($urandom_range(255));
         phase_cfg[p].one_pattern  = CHAN_W'($urandom_range(255));
      end

      // hold reset, then let the clearing pass run under busy
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table at the reset register values
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(dir_rows[i].req, dir_rows[i].has_word, dir_rows[i].word);
      end

      // random phases, each with fresh register values
      for (int p = 0; p < PHASES; p++) begin
         drain_words();
         csr_write(REG_BRIGHTNESS,   DATA_W'(phase_cfg[p].brightness));
         csr_write(REG_ZERO_PATTERN, DATA_W'(phase_cfg[p].zero_pattern));
         csr_write(REG_ONE_PATTERN,  DATA_W'(phase_cfg[p].one_pattern));
         steady = (p == QUIET_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_request(r);
            send_request(r, 1'b0, '0);
         end
      end

      drain_words();
      if (err_count == 0) begin
         $display("led_frame_store_spi_encoder_core test passed");
      end else begin
         $display("led_frame_store_spi_encoder_core test failed");
      end
      $finish;
   end

endmodule
